[sv/indexed_max_heap_queue_defines.svh]
// ============================================================================
// Assertion macros for the indexed max-heap queue
// Shared property forms, clocked on aclk and disabled while aresetn is low.
// ============================================================================
`ifndef INDEXED_MAX_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MAX_HEAP_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMHQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed_max_heap_queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed_max_heap_queue check failed");

`endif

[sv/imhq_pkg.sv]
// ============================================================================
// imhq_pkg
// Shared constants, codes and controller/datapath interface types.
// ============================================================================
package imhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VX_W     = CNT_W;
    localparam int REQ_W    = 3;
    localparam int ST_W     = 2;
    localparam int S_DATA_W = ((VX_W + KEY_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((VX_W + KEY_BITS + CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAPACITY - 1);

    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_EXTRACT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INCREASE = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

    typedef enum logic [4:0] {
        DP_NOP, DP_ACCEPT, DP_SET_ST, DP_CLR_START, DP_SWEEP, DP_APPEND,
        DP_POS_RD, DP_INS_WR, DP_UP_RD, DP_UP_CAP, DP_SWAP1, DP_SWAP2,
        DP_INC_CAP, DP_INC_WR, DP_INC_VCAP, DP_EX_RD1, DP_EX_RDN, DP_EX_CAPN,
        DP_EX_CLR, DP_DN_RDL, DP_DN_RDR, DP_DN_CAPR, DP_BLD_INIT, DP_BLD_RD,
        DP_BLD_CAP, DP_BLD_DEC, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [ST_W-1:0] st_code;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             full;
        logic             empty;
        logic             vx_ok;
        logic             pos_used;
        logic             inc_absent;
        logic             up_more;
        logic             up_greater;
        logic             dn_has_l;
        logic             big_set;
        logic             bld_zero;
        logic             sweep_last;
        logic             out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_INIT_SWEEP, S_IDLE, S_DISPATCH, S_CLR_SWEEP, S_INS_CHK, S_INC_CHK,
        S_INC_WR, S_INC_VCAP, S_UP_TEST, S_UP_CAP, S_UP_SWAP1, S_UP_SWAP2,
        S_EX_RDN, S_EX_CAPN, S_EX_SWAP1, S_EX_SWAP2, S_EX_CLR, S_DN_TEST,
        S_DN_RDR, S_DN_CAPR, S_DN_DEC, S_DN_SWAP1, S_DN_SWAP2, S_BLD_TEST,
        S_BLD_CAP, S_OUT
    } state_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W-1:0] slot);
        logic [CNT_W-1:0] tmp;
        tmp = slot - 1'b1;
        return tmp[ADDR_W-1:0];
    endfunction

endpackage

[sv/imhq_ram.sv]
// ============================================================================
// imhq_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ============================================================================
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/imhq_datapath.sv]
// ============================================================================
// imhq_datapath
// Heap storage, position map, working registers and the result register.
// ============================================================================
module imhq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  imhq_pkg::dp_cmd_t             cmd,
    output imhq_pkg::dp_status_t          status,
    input  logic [imhq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [imhq_pkg::REQ_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imhq_pkg::M_DATA_W-1:0] m_tdata,
    output logic [imhq_pkg::ST_W-1:0]     m_tuser
);

    localparam int AW = imhq_pkg::ADDR_W;
    localparam int CW = imhq_pkg::CNT_W;
    localparam int KW = imhq_pkg::KEY_BITS;
    localparam int VW = imhq_pkg::VX_W;
    localparam int SW = imhq_pkg::ST_W;
    localparam int M_W = imhq_pkg::M_DATA_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] bidx_reg, bidx_next;
    logic [imhq_pkg::REQ_W-1:0] req_reg, req_next;
    logic [VW-1:0] vx_reg, vx_next;
    logic signed [KW-1:0] key_reg, key_next;
    logic [CW-1:0] cur_slot_reg, cur_slot_next;
    logic signed [KW-1:0] cur_key_reg, cur_key_next;
    logic [VW-1:0] cur_vert_reg, cur_vert_next;
    logic [CW-1:0] oth_slot_reg, oth_slot_next;
    logic signed [KW-1:0] oth_key_reg, oth_key_next;
    logic [VW-1:0] oth_vert_reg, oth_vert_next;
    logic big_set_reg, big_set_next;
    logic [VW-1:0] res_v_reg, res_v_next;
    logic signed [KW-1:0] res_k_reg, res_k_next;
    logic [SW-1:0] res_st_reg, res_st_next;
    logic m_valid_reg, m_valid_next;
    logic [M_W-1:0] m_data_reg, m_data_next;
    logic [SW-1:0] m_user_reg, m_user_next;

    logic [AW-1:0] kv_addr, pos_addr;
    logic key_we, vert_we, pos_we;
    logic signed [KW-1:0] key_wdata, key_rdata;
    logic [VW-1:0] vert_wdata, vert_rdata;
    logic [CW-1:0] pos_wdata, pos_rdata;
    logic [CW:0] lslot, rslot;
    logic [CW-1:0] cnt_inc;
    logic signed [KW-1:0] base_key;

    imhq_ram #(.WIDTH(KW), .DEPTH(imhq_pkg::CAPACITY)) u_key_ram (
        .aclk(aclk), .we(key_we), .addr(kv_addr), .wdata(key_wdata), .rdata(key_rdata)
    );
    imhq_ram #(.WIDTH(VW), .DEPTH(imhq_pkg::CAPACITY)) u_vert_ram (
        .aclk(aclk), .we(vert_we), .addr(kv_addr), .wdata(vert_wdata), .rdata(vert_rdata)
    );
    imhq_ram #(.WIDTH(CW), .DEPTH(imhq_pkg::CAPACITY)) u_pos_ram (
        .aclk(aclk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata)
    );

    assign lslot    = {cur_slot_reg, 1'b0};
    assign rslot    = lslot + 1'b1;
    assign cnt_inc  = count_reg + 1'b1;
    assign base_key = big_set_reg ? oth_key_reg : cur_key_reg;

    always_comb begin
        count_next    = count_reg;
        sweep_next    = sweep_reg;
        bidx_next     = bidx_reg;
        req_next      = req_reg;
        vx_next       = vx_reg;
        key_next      = key_reg;
        cur_slot_next = cur_slot_reg;
        cur_key_next  = cur_key_reg;
        cur_vert_next = cur_vert_reg;
        oth_slot_next = oth_slot_reg;
        oth_key_next  = oth_key_reg;
        oth_vert_next = oth_vert_reg;
        big_set_next  = big_set_reg;
        res_v_next    = res_v_reg;
        res_k_next    = res_k_reg;
        res_st_next   = res_st_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        kv_addr    = '0;
        pos_addr   = '0;
        key_we     = 1'b0;
        vert_we    = 1'b0;
        pos_we     = 1'b0;
        key_wdata  = key_reg;
        vert_wdata = vx_reg;
        pos_wdata  = '0;
        case (cmd.op)
            imhq_pkg::DP_ACCEPT: begin
                req_next    = s_tuser;
                vx_next     = s_tdata[VW-1:0];
                key_next    = s_tdata[VW+KW-1:VW];
                res_v_next  = '0;
                res_k_next  = '0;
                res_st_next = imhq_pkg::ST_OK;
            end
            imhq_pkg::DP_SET_ST: begin
                res_st_next = cmd.st_code;
            end
            imhq_pkg::DP_CLR_START: begin
                count_next = '0;
                sweep_next = '0;
            end
            imhq_pkg::DP_SWEEP: begin
                pos_addr   = sweep_reg[AW-1:0];
                pos_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            imhq_pkg::DP_APPEND: begin
                kv_addr    = count_reg[AW-1:0];
                key_we     = 1'b1;
                vert_we    = 1'b1;
                vert_wdata = cnt_inc;
                pos_addr   = count_reg[AW-1:0];
                pos_we     = 1'b1;
                pos_wdata  = cnt_inc;
                count_next = cnt_inc;
            end
            imhq_pkg::DP_POS_RD: begin
                pos_addr = imhq_pkg::slot_addr(vx_reg);
            end
            imhq_pkg::DP_INS_WR: begin
                kv_addr       = count_reg[AW-1:0];
                key_we        = 1'b1;
                vert_we       = 1'b1;
                pos_addr      = imhq_pkg::slot_addr(vx_reg);
                pos_we        = 1'b1;
                pos_wdata     = cnt_inc;
                count_next    = cnt_inc;
                cur_slot_next = cnt_inc;
                cur_key_next  = key_reg;
                cur_vert_next = vx_reg;
            end
            imhq_pkg::DP_UP_RD: begin
                kv_addr       = imhq_pkg::slot_addr(cur_slot_reg >> 1);
                oth_slot_next = cur_slot_reg >> 1;
            end
            imhq_pkg::DP_UP_CAP: begin
                oth_key_next  = key_rdata;
                oth_vert_next = vert_rdata;
            end
            imhq_pkg::DP_SWAP1: begin
                kv_addr    = imhq_pkg::slot_addr(cur_slot_reg);
                key_we     = 1'b1;
                vert_we    = 1'b1;
                key_wdata  = oth_key_reg;
                vert_wdata = oth_vert_reg;
                pos_addr   = imhq_pkg::slot_addr(cur_vert_reg);
                pos_we     = 1'b1;
                pos_wdata  = oth_slot_reg;
            end
            imhq_pkg::DP_SWAP2: begin
                kv_addr       = imhq_pkg::slot_addr(oth_slot_reg);
                key_we        = 1'b1;
                vert_we       = 1'b1;
                key_wdata     = cur_key_reg;
                vert_wdata    = cur_vert_reg;
                pos_addr      = imhq_pkg::slot_addr(oth_vert_reg);
                pos_we        = 1'b1;
                pos_wdata     = cur_slot_reg;
                cur_slot_next = oth_slot_reg;
            end
            imhq_pkg::DP_INC_CAP: begin
                cur_slot_next = pos_rdata;
            end
            imhq_pkg::DP_INC_WR: begin
                kv_addr = imhq_pkg::slot_addr(cur_slot_reg);
                key_we  = 1'b1;
            end
            imhq_pkg::DP_INC_VCAP: begin
                cur_key_next  = key_reg;
                cur_vert_next = vert_rdata;
            end
            imhq_pkg::DP_EX_RD1: begin
                kv_addr = '0;
            end
            imhq_pkg::DP_EX_RDN: begin
                oth_slot_next = CW'(1);
                oth_key_next  = key_rdata;
                oth_vert_next = vert_rdata;
                kv_addr       = imhq_pkg::slot_addr(count_reg);
            end
            imhq_pkg::DP_EX_CAPN: begin
                cur_slot_next = count_reg;
                cur_key_next  = key_rdata;
                cur_vert_next = vert_rdata;
                res_v_next    = oth_vert_reg;
                res_k_next    = oth_key_reg;
            end
            imhq_pkg::DP_EX_CLR: begin
                pos_addr   = imhq_pkg::slot_addr(oth_vert_reg);
                pos_we     = 1'b1;
                count_next = count_reg - 1'b1;
            end
            imhq_pkg::DP_DN_RDL: begin
                kv_addr = imhq_pkg::slot_addr(lslot[CW-1:0]);
            end
            imhq_pkg::DP_DN_RDR: begin
                kv_addr = lslot[AW-1:0];
                if (key_rdata > cur_key_reg) begin
                    oth_slot_next = lslot[CW-1:0];
                    oth_key_next  = key_rdata;
                    oth_vert_next = vert_rdata;
                    big_set_next  = 1'b1;
                end else begin
                    big_set_next = 1'b0;
                end
            end
            imhq_pkg::DP_DN_CAPR: begin
                if (rslot <= {1'b0, count_reg} && key_rdata > base_key) begin
                    oth_slot_next = rslot[CW-1:0];
                    oth_key_next  = key_rdata;
                    oth_vert_next = vert_rdata;
                    big_set_next  = 1'b1;
                end
            end
            imhq_pkg::DP_BLD_INIT: begin
                bidx_next = count_reg >> 1;
            end
            imhq_pkg::DP_BLD_RD: begin
                kv_addr       = imhq_pkg::slot_addr(bidx_reg);
                cur_slot_next = bidx_reg;
            end
            imhq_pkg::DP_BLD_CAP: begin
                cur_key_next  = key_rdata;
                cur_vert_next = vert_rdata;
            end
            imhq_pkg::DP_BLD_DEC: begin
                bidx_next = bidx_reg - 1'b1;
            end
            imhq_pkg::DP_OUT: begin
                m_valid_next = 1'b1;
                m_data_next  = M_W'({count_reg, res_k_reg, res_v_reg});
                m_user_next  = res_st_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
        bidx_reg     <= bidx_next;
        req_reg      <= req_next;
        vx_reg       <= vx_next;
        key_reg      <= key_next;
        cur_slot_reg <= cur_slot_next;
        cur_key_reg  <= cur_key_next;
        cur_vert_reg <= cur_vert_next;
        oth_slot_reg <= oth_slot_next;
        oth_key_reg  <= oth_key_next;
        oth_vert_reg <= oth_vert_next;
        big_set_reg  <= big_set_next;
        res_v_reg    <= res_v_next;
        res_k_reg    <= res_k_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    always_comb begin
        status.req_type   = req_reg;
        status.full       = (count_reg == imhq_pkg::CAP_CNT);
        status.empty      = (count_reg == '0);
        status.vx_ok      = (vx_reg != '0) && (vx_reg <= imhq_pkg::CAP_CNT);
        status.pos_used   = (pos_rdata != '0);
        status.inc_absent = (pos_rdata == '0) || (pos_rdata > count_reg);
        status.up_more    = (cur_slot_reg > CW'(1));
        status.up_greater = (cur_key_reg > key_rdata);
        status.dn_has_l   = (lslot <= {1'b0, count_reg});
        status.big_set    = big_set_reg;
        status.bld_zero   = (bidx_reg == '0);
        status.sweep_last = (sweep_reg == imhq_pkg::LAST_CNT);
        status.out_free   = ~m_valid_reg | m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[sv/imhq_ctrl.sv]
// ============================================================================
// imhq_ctrl
// Sequencer for the heap operations, issuing one datapath command per cycle.
// ============================================================================
module imhq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  imhq_pkg::dp_status_t status,
    output imhq_pkg::dp_cmd_t    cmd
);

    imhq_pkg::state_t state_reg, state_next;
    logic build_reg, build_next;
    logic dn_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imhq_pkg::S_INIT_SWEEP;
            build_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        build_next  = build_reg;
        cmd.op      = imhq_pkg::DP_NOP;
        cmd.st_code = imhq_pkg::ST_OK;
        s_tready    = 1'b0;
        dn_done     = 1'b0;
        case (state_reg)
            imhq_pkg::S_INIT_SWEEP: begin
                cmd.op = imhq_pkg::DP_SWEEP;
                if (status.sweep_last) begin
                    state_next = imhq_pkg::S_IDLE;
                end
            end
            imhq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = imhq_pkg::DP_ACCEPT;
                    state_next = imhq_pkg::S_DISPATCH;
                end
            end
            imhq_pkg::S_DISPATCH: begin
                build_next = (status.req_type == imhq_pkg::REQ_BUILD);
                state_next = imhq_pkg::S_OUT;
                case (status.req_type)
                    imhq_pkg::REQ_CLEAR: begin
                        cmd.op     = imhq_pkg::DP_CLR_START;
                        state_next = imhq_pkg::S_CLR_SWEEP;
                    end
                    imhq_pkg::REQ_APPEND: begin
                        if (status.full) begin
                            cmd.op      = imhq_pkg::DP_SET_ST;
                            cmd.st_code = imhq_pkg::ST_FULL;
                        end else begin
                            cmd.op = imhq_pkg::DP_APPEND;
                        end
                    end
                    imhq_pkg::REQ_BUILD: begin
                        cmd.op     = imhq_pkg::DP_BLD_INIT;
                        state_next = imhq_pkg::S_BLD_TEST;
                    end
                    imhq_pkg::REQ_INSERT: begin
                        if (status.full) begin
                            cmd.op      = imhq_pkg::DP_SET_ST;
                            cmd.st_code = imhq_pkg::ST_FULL;
                        end else if (!status.vx_ok) begin
                            cmd.op      = imhq_pkg::DP_SET_ST;
                            cmd.st_code = imhq_pkg::ST_BAD;
                        end else begin
                            cmd.op     = imhq_pkg::DP_POS_RD;
                            state_next = imhq_pkg::S_INS_CHK;
                        end
                    end
                    imhq_pkg::REQ_EXTRACT: begin
                        if (status.empty) begin
                            cmd.op      = imhq_pkg::DP_SET_ST;
                            cmd.st_code = imhq_pkg::ST_EMPTY;
                        end else begin
                            cmd.op     = imhq_pkg::DP_EX_RD1;
                            state_next = imhq_pkg::S_EX_RDN;
                        end
                    end
                    imhq_pkg::REQ_INCREASE: begin
                        if (!status.vx_ok) begin
                            cmd.op      = imhq_pkg::DP_SET_ST;
                            cmd.st_code = imhq_pkg::ST_BAD;
                        end else begin
                            cmd.op     = imhq_pkg::DP_POS_RD;
                            state_next = imhq_pkg::S_INC_CHK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            imhq_pkg::S_CLR_SWEEP: begin
                cmd.op = imhq_pkg::DP_SWEEP;
                if (status.sweep_last) begin
                    state_next = imhq_pkg::S_OUT;
                end
            end
            imhq_pkg::S_INS_CHK: begin
                if (status.pos_used) begin
                    cmd.op      = imhq_pkg::DP_SET_ST;
                    cmd.st_code = imhq_pkg::ST_BAD;
                    state_next  = imhq_pkg::S_OUT;
                end else begin
                    cmd.op     = imhq_pkg::DP_INS_WR;
                    state_next = imhq_pkg::S_UP_TEST;
                end
            end
            imhq_pkg::S_INC_CHK: begin
                if (status.inc_absent) begin
                    cmd.op      = imhq_pkg::DP_SET_ST;
                    cmd.st_code = imhq_pkg::ST_BAD;
                    state_next  = imhq_pkg::S_OUT;
                end else begin
                    cmd.op     = imhq_pkg::DP_INC_CAP;
                    state_next = imhq_pkg::S_INC_WR;
                end
            end
            imhq_pkg::S_INC_WR: begin
                cmd.op     = imhq_pkg::DP_INC_WR;
                state_next = imhq_pkg::S_INC_VCAP;
            end
            imhq_pkg::S_INC_VCAP: begin
                cmd.op     = imhq_pkg::DP_INC_VCAP;
                state_next = imhq_pkg::S_UP_TEST;
            end
            imhq_pkg::S_UP_TEST: begin
                if (status.up_more) begin
                    cmd.op     = imhq_pkg::DP_UP_RD;
                    state_next = imhq_pkg::S_UP_CAP;
                end else begin
                    state_next = imhq_pkg::S_OUT;
                end
            end
            imhq_pkg::S_UP_CAP: begin
                cmd.op     = imhq_pkg::DP_UP_CAP;
                state_next = status.up_greater ? imhq_pkg::S_UP_SWAP1 : imhq_pkg::S_OUT;
            end
            imhq_pkg::S_UP_SWAP1: begin
                cmd.op     = imhq_pkg::DP_SWAP1;
                state_next = imhq_pkg::S_UP_SWAP2;
            end
            imhq_pkg::S_UP_SWAP2: begin
                cmd.op     = imhq_pkg::DP_SWAP2;
                state_next = imhq_pkg::S_UP_TEST;
            end
            imhq_pkg::S_EX_RDN: begin
                cmd.op     = imhq_pkg::DP_EX_RDN;
                state_next = imhq_pkg::S_EX_CAPN;
            end
            imhq_pkg::S_EX_CAPN: begin
                cmd.op     = imhq_pkg::DP_EX_CAPN;
                state_next = imhq_pkg::S_EX_SWAP1;
            end
            imhq_pkg::S_EX_SWAP1: begin
                cmd.op     = imhq_pkg::DP_SWAP1;
                state_next = imhq_pkg::S_EX_SWAP2;
            end
            imhq_pkg::S_EX_SWAP2: begin
                cmd.op     = imhq_pkg::DP_SWAP2;
                state_next = imhq_pkg::S_EX_CLR;
            end
            imhq_pkg::S_EX_CLR: begin
                cmd.op     = imhq_pkg::DP_EX_CLR;
                state_next = imhq_pkg::S_DN_TEST;
            end
            imhq_pkg::S_DN_TEST: begin
                if (status.dn_has_l) begin
                    cmd.op     = imhq_pkg::DP_DN_RDL;
                    state_next = imhq_pkg::S_DN_RDR;
                end else begin
                    dn_done = 1'b1;
                end
            end
            imhq_pkg::S_DN_RDR: begin
                cmd.op     = imhq_pkg::DP_DN_RDR;
                state_next = imhq_pkg::S_DN_CAPR;
            end
            imhq_pkg::S_DN_CAPR: begin
                cmd.op     = imhq_pkg::DP_DN_CAPR;
                state_next = imhq_pkg::S_DN_DEC;
            end
            imhq_pkg::S_DN_DEC: begin
                if (status.big_set) begin
                    state_next = imhq_pkg::S_DN_SWAP1;
                end else begin
                    dn_done = 1'b1;
                end
            end
            imhq_pkg::S_DN_SWAP1: begin
                cmd.op     = imhq_pkg::DP_SWAP1;
                state_next = imhq_pkg::S_DN_SWAP2;
            end
            imhq_pkg::S_DN_SWAP2: begin
                cmd.op     = imhq_pkg::DP_SWAP2;
                state_next = imhq_pkg::S_DN_TEST;
            end
            imhq_pkg::S_BLD_TEST: begin
                if (status.bld_zero) begin
                    state_next = imhq_pkg::S_OUT;
                end else begin
                    cmd.op     = imhq_pkg::DP_BLD_RD;
                    state_next = imhq_pkg::S_BLD_CAP;
                end
            end
            imhq_pkg::S_BLD_CAP: begin
                cmd.op     = imhq_pkg::DP_BLD_CAP;
                state_next = imhq_pkg::S_DN_TEST;
            end
            imhq_pkg::S_OUT: begin
                if (status.out_free) begin
                    cmd.op     = imhq_pkg::DP_OUT;
                    state_next = imhq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = imhq_pkg::S_IDLE;
            end
        endcase
        if (dn_done) begin
            if (build_reg) begin
                cmd.op     = imhq_pkg::DP_BLD_DEC;
                state_next = imhq_pkg::S_BLD_TEST;
            end else begin
                state_next = imhq_pkg::S_OUT;
            end
        end
    end

endmodule

[sv/indexed_max_heap_queue.sv]
// ============================================================================
// indexed_max_heap_queue
// Indexed binary max-heap of (vertex, key) pairs with a vertex position map.
// ============================================================================
// Requests enter on the s_ channel (s_tuser = request type, s_tdata = vertex
// and key) and each one returns exactly one result on the m_ channel
// (m_tdata = removed vertex, removed key, count after; m_tuser = status).
// One request is worked on at a time over single-port heap and position
// memories. Each sift-up level tests the slot, reads the parent and, if the
// key is larger, swaps in two writes; a sift-down level reads both children
// and swaps with the larger one in two writes if it beats the current key.
// Insert and increase-key sift up (up to 10 levels), extract-max sifts down.
// Build runs sift-down from every parent slot. Clear sweeps the 1024-entry
// position map; after aresetn the same sweep runs with s_tready low.
// A finished result sits in the output register; the next request is taken
// while it waits, and that request's result is held back until m_tready
// frees the register.
module indexed_max_heap_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [10:0] vertex_id, [42:11] key_value, rest zero
    input  logic [imhq_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  logic [imhq_pkg::REQ_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] out_vertex, [42:11] out_key, [53:43] count_after, rest zero
    output logic [imhq_pkg::M_DATA_W-1:0] m_tdata,
    // [1:0] status_code
    output logic [imhq_pkg::ST_W-1:0]     m_tuser
);

    imhq_pkg::dp_cmd_t    cmd;
    imhq_pkg::dp_status_t status;

    imhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    imhq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[sv/imhq_checker.sv]
// ============================================================================
// imhq_checker
// Port-level checks on the request and result channels of the heap queue.
// ============================================================================
`include "indexed_max_heap_queue_defines.svh"

module imhq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [imhq_pkg::M_DATA_W-1:0] m_tdata,
    input logic [imhq_pkg::ST_W-1:0]     m_tuser
);

    localparam int VW = imhq_pkg::VX_W;
    localparam int KW = imhq_pkg::KEY_BITS;
    localparam int CW = imhq_pkg::CNT_W;

    logic [VW-1:0] out_vertex;
    logic [KW-1:0] out_key;
    logic [CW-1:0] count_after;

    assign out_vertex  = m_tdata[VW-1:0];
    assign out_key     = m_tdata[VW+KW-1:VW];
    assign count_after = m_tdata[VW+KW+CW-1:VW+KW];

    `IMHQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `IMHQ_ASSERT_NEXT(a_single_request, s_tvalid && s_tready, !s_tready)
    `IMHQ_ASSERT_NOW(a_empty, m_tvalid && m_tuser == imhq_pkg::ST_EMPTY, count_after == '0 && out_vertex == '0 && out_key == '0)
    `IMHQ_ASSERT_NOW(a_full, m_tvalid && m_tuser == imhq_pkg::ST_FULL, count_after == imhq_pkg::CAP_CNT && out_vertex == '0)
    `IMHQ_ASSERT_NOW(a_removed, m_tvalid && out_vertex != '0, m_tuser == imhq_pkg::ST_OK && count_after < imhq_pkg::CAP_CNT)

endmodule

bind indexed_max_heap_queue imhq_checker u_imhq_checker (.*);
